>>> rtl/gsr_pkg.sv
// gsr_pkg: shared types and constants for the i2c gas sensor reader
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package gsr_pkg;

  // bus constants
  localparam logic [7:0]  ADDR_WR_BYTE   = 8'hB0;
  localparam logic [7:0]  ADDR_RD_BYTE   = 8'hB1;
  localparam logic [15:0] SERIAL_CMD     = {8'h36, 8'h82};
  localparam logic [15:0] ECO2_MIN       = 16'd400;
  localparam logic [15:0] VALUE_MAX      = 16'd60000;
  localparam logic [3:0]  MEASURE_BYTES  = 4'd6;
  localparam logic [3:0]  SERIAL_BYTES   = 4'd9;
  localparam logic [3:0]  CMD_BYTES      = 4'd3;
  localparam logic [3:0]  BITS_PER_BYTE  = 4'd8;

  // operation codes
  localparam logic [1:0] FN_WRITE   = 2'd0;
  localparam logic [1:0] FN_MEASURE = 2'd1;
  localparam logic [1:0] FN_SERIAL  = 2'd2;
  localparam logic [1:0] FN_UNUSED  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NACK  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // configuration register indexes and reset values
  localparam logic [1:0]  CFG_MEASURE_CMD  = 2'd0;
  localparam logic [1:0]  CFG_MEASURE_WAIT = 2'd1;
  localparam logic [1:0]  CFG_SERIAL_WAIT  = 2'd2;
  localparam logic [15:0] MEASURE_CMD_RST  = 16'd8200;
  localparam logic [19:0] MEASURE_WAIT_RST = 20'd12000;
  localparam logic [19:0] SERIAL_WAIT_RST  = 20'd20000;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 72;

  typedef struct packed {
    logic        start_request;
    logic [1:0]  func;
    logic [15:0] command_word;
    logic        sda_sample;
  } gsr_item_t;

  typedef struct packed {
    logic        scl_level;
    logic        sda_level;
    logic        busy_res;
    logic        done_res;
    logic [1:0]  status;
    logic [15:0] eco2_ppm;
    logic [15:0] tvoc_ppb;
    logic [31:0] serial_number;
  } gsr_result_t;

  typedef struct packed {
    logic [15:0] measure_command;
    logic [19:0] measure_wait_ticks;
    logic [19:0] serial_wait_ticks;
  } gsr_cfg_t;

endpackage

>>> rtl/gsr_cfg_regs.sv
// gsr_cfg_regs: configuration registers of the i2c gas sensor reader
// depends on gsr_pkg
`timescale 1ns / 1ps

module gsr_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [1:0]        wr_index,
  input  logic [19:0]       wr_data,
  output gsr_pkg::gsr_cfg_t cfg
);
  import gsr_pkg::*;

  gsr_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.measure_command    <= MEASURE_CMD_RST;
      cfg_r.measure_wait_ticks <= MEASURE_WAIT_RST;
      cfg_r.serial_wait_ticks  <= SERIAL_WAIT_RST;
    end else if (wr_en) begin
      case (wr_index)
        CFG_MEASURE_CMD:  cfg_r.measure_command    <= wr_data[15:0];
        CFG_MEASURE_WAIT: cfg_r.measure_wait_ticks <= wr_data;
        CFG_SERIAL_WAIT:  cfg_r.serial_wait_ticks  <= wr_data;
        default: ;  // writes beyond the list are dropped
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/gsr_seq.sv
// gsr_seq: tick-level i2c bus sequencer, state and next-tick logic
// depends on gsr_pkg; the result is registered by the top level
`timescale 1ns / 1ps

module gsr_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  gsr_pkg::gsr_item_t   item,
  input  gsr_pkg::gsr_cfg_t    cfg,
  output gsr_pkg::gsr_result_t res
);
  import gsr_pkg::*;

  typedef enum logic [7:0] {
    PH_IDLE  = 8'b0000_0001,
    PH_START = 8'b0000_0010,
    PH_SEND  = 8'b0000_0100,
    PH_ACKW  = 8'b0000_1000,
    PH_STOP  = 8'b0001_0000,
    PH_WAIT  = 8'b0010_0000,
    PH_READ  = 8'b0100_0000,
    PH_MACK  = 8'b1000_0000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  operation_r, operation_nxt;
  logic [15:0] command_hold_r, command_hold_nxt;
  logic [3:0]  bit_count_r, bit_count_nxt;
  logic [3:0]  byte_count_r, byte_count_nxt;
  logic [7:0]  shift_byte_r, shift_byte_nxt;
  logic [19:0] wait_count_r, wait_count_nxt;
  logic [1:0]  tick_sub_r, tick_sub_nxt;
  logic        leg_r, leg_nxt;
  logic        failed_r, failed_nxt;
  logic [1:0]  last_status_r, last_status_nxt;
  logic [15:0] eco2_hold_r, eco2_hold_nxt;
  logic [15:0] tvoc_hold_r, tvoc_hold_nxt;
  logic [31:0] serial_hold_r, serial_hold_nxt;
  // only bytes 0, 1, 3 and 4 of a read are ever used
  logic [7:0]  rx_r [4];
  logic [7:0]  rx_nxt [4];

  logic        scl, sda, busy, done;
  logic [3:0]  read_total;
  logic [15:0] eco2_val, tvoc_val;
  logic [19:0] wait_len;

  function automatic logic [7:0] send_byte(input logic leg, input logic [3:0] bc,
                                           input logic [15:0] cmd);
    logic [7:0] b;
    if (leg)            b = ADDR_RD_BYTE;
    else if (bc == 4'd0) b = ADDR_WR_BYTE;
    else if (bc == 4'd1) b = cmd[15:8];
    else                 b = cmd[7:0];
    return b;
  endfunction

  assign eco2_val = {rx_r[0], rx_r[1]};
  assign tvoc_val = {rx_r[2], rx_r[3]};

  always_comb begin
    phase_nxt        = phase_r;
    operation_nxt    = operation_r;
    command_hold_nxt = command_hold_r;
    bit_count_nxt    = bit_count_r;
    byte_count_nxt   = byte_count_r;
    shift_byte_nxt   = shift_byte_r;
    wait_count_nxt   = wait_count_r;
    tick_sub_nxt     = tick_sub_r;
    leg_nxt          = leg_r;
    failed_nxt       = failed_r;
    last_status_nxt  = last_status_r;
    eco2_hold_nxt    = eco2_hold_r;
    tvoc_hold_nxt    = tvoc_hold_r;
    serial_hold_nxt  = serial_hold_r;
    rx_nxt           = rx_r;
    scl              = 1'b1;
    sda              = 1'b1;
    done             = 1'b0;

    // the accepting tick is already the first start tick
    if (phase_r == PH_IDLE && item.start_request && item.func != FN_UNUSED) begin
      operation_nxt = item.func;
      case (item.func)
        FN_WRITE:   command_hold_nxt = item.command_word;
        FN_MEASURE: command_hold_nxt = cfg.measure_command;
        default:    command_hold_nxt = SERIAL_CMD;
      endcase
      failed_nxt     = 1'b0;
      leg_nxt        = 1'b0;
      byte_count_nxt = 4'd0;
      tick_sub_nxt   = 2'd0;
      phase_nxt      = PH_START;
    end

    busy       = phase_nxt != PH_IDLE;
    read_total = (operation_nxt == FN_MEASURE) ? MEASURE_BYTES : SERIAL_BYTES;
    wait_len   = (operation_nxt == FN_MEASURE) ? cfg.measure_wait_ticks
                                               : cfg.serial_wait_ticks;

    case (phase_nxt)
      PH_IDLE: ;
      PH_START: begin
        sda = tick_sub_nxt < 2'd2;
        if (tick_sub_nxt == 2'd3) begin
          shift_byte_nxt = send_byte(leg_nxt, byte_count_nxt, command_hold_nxt);
          bit_count_nxt  = 4'd0;
          tick_sub_nxt   = 2'd0;
          phase_nxt      = PH_SEND;
        end else begin
          tick_sub_nxt = tick_sub_nxt + 2'd1;
        end
      end
      PH_SEND: begin
        scl = tick_sub_nxt[0];
        sda = shift_byte_nxt[7];
        if (tick_sub_nxt == 2'd0) begin
          tick_sub_nxt = 2'd1;
        end else begin
          shift_byte_nxt = {shift_byte_nxt[6:0], 1'b0};
          bit_count_nxt  = bit_count_nxt + 4'd1;
          tick_sub_nxt   = 2'd0;
          if (bit_count_nxt >= BITS_PER_BYTE) phase_nxt = PH_ACKW;
        end
      end
      PH_ACKW: begin
        scl = tick_sub_nxt == 2'd1;
        if (tick_sub_nxt == 2'd1) begin
          failed_nxt   = item.sda_sample;
          tick_sub_nxt = 2'd2;
        end else if (tick_sub_nxt == 2'd0) begin
          tick_sub_nxt = 2'd1;
        end else if (failed_nxt) begin
          tick_sub_nxt = 2'd0;
          phase_nxt    = PH_STOP;
        end else if (!leg_nxt) begin
          byte_count_nxt = byte_count_nxt + 4'd1;
          if (byte_count_nxt < CMD_BYTES) begin
            shift_byte_nxt = send_byte(leg_nxt, byte_count_nxt, command_hold_nxt);
            bit_count_nxt  = 4'd0;
            tick_sub_nxt   = 2'd0;
            phase_nxt      = PH_SEND;
          end else begin
            failed_nxt   = 1'b0;
            tick_sub_nxt = 2'd0;
            phase_nxt    = PH_STOP;
          end
        end else begin
          byte_count_nxt = 4'd0;
          shift_byte_nxt = 8'd0;
          bit_count_nxt  = 4'd0;
          tick_sub_nxt   = 2'd0;
          phase_nxt      = PH_READ;
        end
      end
      PH_READ: begin
        scl = tick_sub_nxt == 2'd0;
        if (tick_sub_nxt == 2'd0) begin
          shift_byte_nxt = {shift_byte_nxt[6:0], item.sda_sample};
          tick_sub_nxt   = 2'd1;
        end else begin
          bit_count_nxt = bit_count_nxt + 4'd1;
          tick_sub_nxt  = 2'd0;
          if (bit_count_nxt >= BITS_PER_BYTE) phase_nxt = PH_MACK;
        end
      end
      PH_MACK: begin
        // ack every byte but the last one
        sda = !(({1'b0, byte_count_nxt} + 5'd1) < {1'b0, read_total});
        scl = tick_sub_nxt[0];
        if (tick_sub_nxt == 2'd0) begin
          tick_sub_nxt = 2'd1;
        end else begin
          case (byte_count_nxt)
            4'd0:    rx_nxt[0] = shift_byte_nxt;
            4'd1:    rx_nxt[1] = shift_byte_nxt;
            4'd3:    rx_nxt[2] = shift_byte_nxt;
            4'd4:    rx_nxt[3] = shift_byte_nxt;
            default: ;
          endcase
          byte_count_nxt = byte_count_nxt + 4'd1;
          if (byte_count_nxt >= read_total) begin
            failed_nxt   = 1'b0;
            tick_sub_nxt = 2'd0;
            phase_nxt    = PH_STOP;
          end else begin
            shift_byte_nxt = 8'd0;
            bit_count_nxt  = 4'd0;
            tick_sub_nxt   = 2'd0;
            phase_nxt      = PH_READ;
          end
        end
      end
      PH_STOP: begin
        sda = !(tick_sub_nxt < 2'd2);
        if (tick_sub_nxt != 2'd3) begin
          tick_sub_nxt = tick_sub_nxt + 2'd1;
        end else if (failed_nxt) begin
          last_status_nxt = ST_NACK;
          done            = 1'b1;
          phase_nxt       = PH_IDLE;
        end else if (leg_nxt) begin
          if (operation_nxt == FN_MEASURE) begin
            if (eco2_val < ECO2_MIN || eco2_val > VALUE_MAX || tvoc_val > VALUE_MAX) begin
              eco2_hold_nxt   = 16'd0;
              tvoc_hold_nxt   = 16'd0;
              last_status_nxt = ST_RANGE;
            end else begin
              eco2_hold_nxt   = eco2_val;
              tvoc_hold_nxt   = tvoc_val;
              last_status_nxt = ST_OK;
            end
          end else begin
            serial_hold_nxt = {eco2_val, tvoc_val};
            last_status_nxt = ST_OK;
          end
          done      = 1'b1;
          phase_nxt = PH_IDLE;
        end else if (operation_nxt == FN_WRITE) begin
          last_status_nxt = ST_OK;
          done            = 1'b1;
          phase_nxt       = PH_IDLE;
        end else if (wait_len == 20'd0) begin
          leg_nxt        = 1'b1;
          byte_count_nxt = 4'd0;
          tick_sub_nxt   = 2'd0;
          phase_nxt      = PH_START;
        end else begin
          wait_count_nxt = wait_len;
          phase_nxt      = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (wait_count_nxt != 20'd0) wait_count_nxt = wait_count_nxt - 20'd1;
        if (wait_count_nxt == 20'd0) begin
          leg_nxt        = 1'b1;
          byte_count_nxt = 4'd0;
          tick_sub_nxt   = 2'd0;
          phase_nxt      = PH_START;
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      operation_r    <= 2'd0;
      command_hold_r <= 16'd0;
      bit_count_r    <= 4'd0;
      byte_count_r   <= 4'd0;
      shift_byte_r   <= 8'd0;
      wait_count_r   <= 20'd0;
      tick_sub_r     <= 2'd0;
      leg_r          <= 1'b0;
      failed_r       <= 1'b0;
      last_status_r  <= ST_OK;
      eco2_hold_r    <= 16'd0;
      tvoc_hold_r    <= 16'd0;
      serial_hold_r  <= 32'd0;
    end else if (step) begin
      phase_r        <= phase_nxt;
      operation_r    <= operation_nxt;
      command_hold_r <= command_hold_nxt;
      bit_count_r    <= bit_count_nxt;
      byte_count_r   <= byte_count_nxt;
      shift_byte_r   <= shift_byte_nxt;
      wait_count_r   <= wait_count_nxt;
      tick_sub_r     <= tick_sub_nxt;
      leg_r          <= leg_nxt;
      failed_r       <= failed_nxt;
      last_status_r  <= last_status_nxt;
      eco2_hold_r    <= eco2_hold_nxt;
      tvoc_hold_r    <= tvoc_hold_nxt;
      serial_hold_r  <= serial_hold_nxt;
    end
  end

  // received bytes need no reset
  always_ff @(posedge clk) begin
    if (step) rx_r <= rx_nxt;
  end

  always_comb begin
    res.scl_level     = scl;
    res.sda_level     = sda;
    res.busy_res      = busy;
    res.done_res      = done;
    res.status        = last_status_nxt;
    res.eco2_ppm      = eco2_hold_nxt;
    res.tvoc_ppb      = tvoc_hold_nxt;
    res.serial_number = serial_hold_nxt;
  end

`ifndef SYNTHESIS
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    step && done |-> busy)
    else $error("done without busy");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && done |=> phase_r == PH_IDLE)
    else $error("sequencer not idle after done");

  a_idle_bus: assert property (@(posedge clk) disable iff (!rst_n)
    step && phase_r == PH_IDLE && !busy |-> scl && sda && !done)
    else $error("bus driven while idle");

  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_count_r <= BITS_PER_BYTE && byte_count_r <= SERIAL_BYTES)
    else $error("bit or byte count out of range");

  a_stop_high_scl: assert property (@(posedge clk) disable iff (!rst_n)
    step && (phase_r == PH_STOP || phase_r == PH_START || phase_r == PH_WAIT) |-> scl)
    else $error("scl low outside a clocked phase");
`endif

endmodule

>>> rtl/i2c_gas_sensor_reader.sv
// i2c_gas_sensor_reader: top level, stream ports, input and result registers
// depends on gsr_pkg, gsr_cfg_regs and gsr_seq
`timescale 1ns / 1ps

// Tick-driven I2C master for a gas sensor at device address 0x58. Every input
// word is one bus tick (nominally one microsecond): it carries the SDA level
// sampled during that tick and an optional start request, and every input
// word yields exactly one output word with the SCL/SDA drive levels for that
// tick, busy/done flags, the status of the last finished operation and the
// latest eco2, tvoc and serial number values. Operations: write a command,
// measure air quality (measure command, programmable wait, six-byte read with
// range check) and read the serial number (0x3682, wait, nine-byte read).
// A NACK ends the transaction with a stop and status 1; CRC bytes are not
// checked. Throughput is one word per clock while out_tready is high: the
// word sits in an input register, one pass of next-tick logic in the
// sequencer updates the bus state, and the result lands in an output
// register, from which it leaves when out_tready is high.
// The input register holds a further word while a result waits on
// out_tready. Configuration writes are taken at any time on the cfg port but
// should only be issued while idle.

module i2c_gas_sensor_reader (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata, lowest bit up: start_request[0], func[2:1],
  // command_word[18:3], sda_sample[19], zero pad[23:20]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [gsr_pkg::IN_TDATA_W-1:0] in_tdata,
  // out_tdata, lowest bit up: scl_level[0], sda_level[1], busy_res[2],
  // done_res[3], status[5:4], eco2_ppm[21:6], tvoc_ppb[37:22],
  // serial_number[69:38], zero pad[71:70]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [gsr_pkg::OUT_TDATA_W-1:0] out_tdata,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);
  import gsr_pkg::*;

  logic        in_vld_r;
  gsr_item_t   in_item_r;
  logic        out_vld_r;
  gsr_result_t out_res_r;
  gsr_result_t seq_res;
  gsr_cfg_t    cfg;
  logic        step;

  // one tick advances when the input word is held and the result slot frees
  assign step      = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || step;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_tready) in_vld_r <= in_tvalid;
      if (step) out_vld_r <= 1'b1;
      else if (out_tready) out_vld_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r.start_request <= in_tdata[0];
      in_item_r.func          <= in_tdata[2:1];
      in_item_r.command_word  <= in_tdata[18:3];
      in_item_r.sda_sample    <= in_tdata[19];
    end
    if (step) out_res_r <= seq_res;
  end

  gsr_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  gsr_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (in_item_r),
    .cfg   (cfg),
    .res   (seq_res)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00,
                       out_res_r.serial_number,
                       out_res_r.tvoc_ppb,
                       out_res_r.eco2_ppm,
                       out_res_r.status,
                       out_res_r.done_res,
                       out_res_r.busy_res,
                       out_res_r.sda_level,
                       out_res_r.scl_level};

endmodule
